### rtl/sclru_pkg.sv
`timescale 1ns / 1ps

package sclru_pkg;

  localparam int SLOTS   = 64;
  localparam int IDX_W   = $clog2(SLOTS);
  localparam int DEV_W   = 3;
  localparam int SEC_W   = 32;
  localparam int TAG_W   = DEV_W + SEC_W;
  localparam int STAMP_W = 64;
  localparam int SLOT_W  = 6;

  typedef enum logic [1:0] {
    ST_HIT    = 2'd0,
    ST_MISS   = 2'd1,
    ST_BUSY   = 2'd2,
    ST_UNHELD = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_LAST,
    S_FINISH
  } state_t;

  // Outcome of one pass over all slots.
  typedef struct packed {
    logic             hit;
    logic [IDX_W-1:0] hit_idx;
    logic             vic;
    logic [IDX_W-1:0] vic_idx;
    logic [DEV_W-1:0] vic_dev;
    logic [SEC_W-1:0] vic_sec;
  } scan_res_t;

endpackage

### rtl/sclru_ram.sv
`timescale 1ns / 1ps

module sclru_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### rtl/sclru_scan.sv
`timescale 1ns / 1ps

module sclru_scan (
  input  logic                      clk,
  input  logic                      start,
  input  logic                      vld,
  input  logic [sclru_pkg::IDX_W-1:0]   idx,
  input  logic                      need_held,
  input  logic                      slot_valid,
  input  logic                      slot_held,
  input  logic                      stamp_ok,
  input  logic [sclru_pkg::DEV_W-1:0]   tag_dev,
  input  logic [sclru_pkg::SEC_W-1:0]   tag_sec,
  input  logic [sclru_pkg::STAMP_W-1:0] stamp,
  input  logic [sclru_pkg::DEV_W-1:0]   req_dev,
  input  logic [sclru_pkg::SEC_W-1:0]   req_sec,
  output sclru_pkg::scan_res_t      res
);

  import sclru_pkg::*;

  scan_res_t        res_r, res_nxt;
  logic [STAMP_W-1:0] best_r, best_nxt;
  logic [STAMP_W-1:0] cur_stamp;
  logic             match;
  logic             better;

  always_comb begin
    // Slots never released carry a stamp of zero.
    cur_stamp = stamp_ok ? stamp : '0;
    match     = slot_valid && (!need_held || slot_held) &&
                (tag_dev == req_dev) && (tag_sec == req_sec);
    better    = !slot_held && (!res_r.vic || (cur_stamp < best_r));
    res_nxt   = res_r;
    best_nxt  = best_r;
    if (start) begin
      res_nxt  = '0;
      best_nxt = '0;
    end else if (vld) begin
      if (match && !res_r.hit) begin
        res_nxt.hit     = 1'b1;
        res_nxt.hit_idx = idx;
      end
      if (better) begin
        res_nxt.vic     = 1'b1;
        res_nxt.vic_idx = idx;
        res_nxt.vic_dev = tag_dev;
        res_nxt.vic_sec = tag_sec;
        best_nxt        = cur_stamp;
      end
    end
  end

  always_ff @(posedge clk) begin
    res_r  <= res_nxt;
    best_r <= best_nxt;
  end

  assign res = res_r;

endmodule

### rtl/sector_cache_lru_directory_top.sv
`timescale 1ns / 1ps

// Tag directory of a fully associative copy-back sector cache with 64 slots.
// Each map or unmap item walks every slot once through a single tag and
// stamp comparator, reading one slot per cycle from the tag and stamp RAMs.
// The result is presented once the walk is done, and in_ready rises in that
// same cycle, so an item is accepted only after the result of the one before
// it is presented. A result still waiting for out_ready holds the next item in
// its final cycle until the result is taken.
// in_ready is high only while no item is being worked on. A miss picks the
// unheld slot with the oldest release stamp, lowest index on ties; a held hit
// or a full set of held slots answers busy without changing any state.

module sector_cache_lru_directory_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_kind,
  input  logic [2:0]  in_device_id,
  input  logic [31:0] in_sector,
  input  logic        in_coherent,
  input  logic        in_dirty_release,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [5:0]  out_slot,
  output logic        out_dirty_evict,
  output logic [2:0]  out_old_device,
  output logic [31:0] out_old_sector,
  output logic        out_fetch_needed
);

  import sclru_pkg::*;

  state_t             state_r, state_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic               dvld_r;
  logic [IDX_W-1:0]   didx_r;

  logic               req_kind_r, req_coh_r, req_dirty_r;
  logic [DEV_W-1:0]   req_dev_r;
  logic [SEC_W-1:0]   req_sec_r;

  logic [SLOTS-1:0]   valid_r, held_r, dirty_r, stamp_ok_r;
  logic [STAMP_W-1:0] use_cnt_r;

  logic               out_valid_r;
  status_t            out_status_r, out_status_nxt;
  logic [SLOT_W-1:0]  out_slot_r, out_slot_nxt;
  logic               out_wb_r, out_wb_nxt;
  logic [DEV_W-1:0]   out_odev_r, out_odev_nxt;
  logic [SEC_W-1:0]   out_osec_r, out_osec_nxt;
  logic               out_fetch_r, out_fetch_nxt;

  logic               accept, scan_start, commit;
  logic               tag_we, stamp_we;
  logic               do_release, do_grant_hit, do_miss;
  logic [TAG_W-1:0]   tag_rdata;
  logic [STAMP_W-1:0] stamp_rdata;
  scan_res_t          res;

  sclru_ram #(.WIDTH(TAG_W), .DEPTH(SLOTS)) u_tag_ram (
    .clk   (clk),
    .we    (tag_we),
    .waddr (res.vic_idx),
    .wdata ({req_dev_r, req_sec_r}),
    .raddr (idx_r),
    .rdata (tag_rdata)
  );

  sclru_ram #(.WIDTH(STAMP_W), .DEPTH(SLOTS)) u_stamp_ram (
    .clk   (clk),
    .we    (stamp_we),
    .waddr (res.hit_idx),
    .wdata (use_cnt_r),
    .raddr (idx_r),
    .rdata (stamp_rdata)
  );

  sclru_scan u_scan (
    .clk        (clk),
    .start      (scan_start),
    .vld        (dvld_r),
    .idx        (didx_r),
    .need_held  (req_kind_r),
    .slot_valid (valid_r[didx_r]),
    .slot_held  (held_r[didx_r]),
    .stamp_ok   (stamp_ok_r[didx_r]),
    .tag_dev    (tag_rdata[TAG_W-1:SEC_W]),
    .tag_sec    (tag_rdata[SEC_W-1:0]),
    .stamp      (stamp_rdata),
    .req_dev    (req_dev_r),
    .req_sec    (req_sec_r),
    .res        (res)
  );

  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    in_ready       = (state_r == S_IDLE);
    accept         = in_valid && in_ready;
    scan_start     = accept;
    commit         = 1'b0;
    tag_we         = 1'b0;
    stamp_we       = 1'b0;
    do_release     = 1'b0;
    do_grant_hit   = 1'b0;
    do_miss        = 1'b0;
    out_status_nxt = ST_HIT;
    out_slot_nxt   = '0;
    out_wb_nxt     = 1'b0;
    out_odev_nxt   = '0;
    out_osec_nxt   = '0;
    out_fetch_nxt  = 1'b0;

    case (state_r)
      S_IDLE: begin
        idx_nxt = '0;
        if (accept) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        idx_nxt = idx_r + IDX_W'(1);
        if (idx_r == IDX_W'(SLOTS - 1)) begin
          state_nxt = S_LAST;
        end
      end
      S_LAST: begin
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        commit = !out_valid_r || out_ready;
        if (req_kind_r) begin
          if (res.hit) begin
            out_status_nxt = ST_HIT;
            out_slot_nxt   = SLOT_W'(res.hit_idx);
            do_release     = commit;
          end else begin
            out_status_nxt = ST_UNHELD;
          end
        end else if (res.hit) begin
          out_slot_nxt = SLOT_W'(res.hit_idx);
          if (held_r[res.hit_idx]) begin
            out_status_nxt = ST_BUSY;
          end else begin
            out_status_nxt = ST_HIT;
            do_grant_hit   = commit;
          end
        end else if (res.vic) begin
          out_status_nxt = ST_MISS;
          out_slot_nxt   = SLOT_W'(res.vic_idx);
          out_wb_nxt     = valid_r[res.vic_idx] && dirty_r[res.vic_idx];
          out_odev_nxt   = out_wb_nxt ? res.vic_dev : '0;
          out_osec_nxt   = out_wb_nxt ? res.vic_sec : '0;
          out_fetch_nxt  = req_coh_r;
          do_miss        = commit;
        end else begin
          out_status_nxt = ST_BUSY;
        end
        tag_we   = do_miss;
        stamp_we = do_release;
        if (commit) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      dvld_r      <= 1'b0;
      valid_r     <= '0;
      held_r      <= '0;
      dirty_r     <= '0;
      stamp_ok_r  <= '0;
      use_cnt_r   <= STAMP_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      dvld_r  <= (state_r == S_SCAN);
      if (do_release) begin
        held_r[res.hit_idx]     <= 1'b0;
        stamp_ok_r[res.hit_idx] <= 1'b1;
        use_cnt_r               <= use_cnt_r + STAMP_W'(1);
        if (req_dirty_r) begin
          dirty_r[res.hit_idx] <= 1'b1;
        end
      end
      if (do_grant_hit) begin
        held_r[res.hit_idx] <= 1'b1;
      end
      if (do_miss) begin
        valid_r[res.vic_idx] <= 1'b1;
        dirty_r[res.vic_idx] <= 1'b0;
        held_r[res.vic_idx]  <= 1'b1;
      end
      if (commit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    didx_r <= idx_r;
    if (accept) begin
      req_kind_r  <= in_kind;
      req_dev_r   <= in_device_id;
      req_sec_r   <= in_sector;
      req_coh_r   <= in_coherent;
      req_dirty_r <= in_dirty_release;
    end
    if (commit) begin
      out_status_r <= out_status_nxt;
      out_slot_r   <= out_slot_nxt;
      out_wb_r     <= out_wb_nxt;
      out_odev_r   <= out_odev_nxt;
      out_osec_r   <= out_osec_nxt;
      out_fetch_r  <= out_fetch_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_slot         = out_slot_r;
  assign out_dirty_evict  = out_wb_r;
  assign out_old_device   = out_odev_r;
  assign out_old_sector   = out_osec_r;
  assign out_fetch_needed = out_fetch_r;

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import sclru_pkg::*;

  localparam logic KIND_MAP   = 1'b0;
  localparam logic KIND_UNMAP = 1'b1;
  localparam int   POOL       = 16;
  localparam int   LONG_HOLD  = 400;
  localparam int   SETTLE     = 80;

  typedef struct packed {
    logic        kind;
    logic [2:0]  dev;
    logic [31:0] sec;
    logic        coh;
    logic        dirty;
  } access_t;

  typedef struct packed {
    status_t     status;
    logic [5:0]  slot;
    logic        wb;
    logic [2:0]  odev;
    logic [31:0] osec;
    logic        fetch;
  } grant_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_kind = 1'b0;
  logic [2:0]  in_device_id = '0;
  logic [31:0] in_sector = '0;
  logic        in_coherent = 1'b0;
  logic        in_dirty_release = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_status;
  logic [5:0]  out_slot;
  logic        out_dirty_evict;
  logic [2:0]  out_old_device;
  logic [31:0] out_old_sector;
  logic        out_fetch_needed;

  // Shadow copy of the directory, advanced at each accepted item.
  logic               dir_valid [SLOTS];
  logic [DEV_W-1:0]   dir_dev   [SLOTS];
  logic [SEC_W-1:0]   dir_sec   [SLOTS];
  logic [STAMP_W-1:0] dir_stamp [SLOTS];
  logic               dir_dirty [SLOTS];
  logic               dir_held  [SLOTS];
  logic [STAMP_W-1:0] use_ctr;

  logic [2:0]  pool_dev [POOL];
  logic [31:0] pool_sec [POOL];

  grant_t grant_q[$];
  grant_t head;

  bit tx_idle = 1'b1;
  bit rx_idle = 1'b1;
  bit hold_req = 1'b0;
  int n_fail = 0;
  int n_sent = 0;
  int n_hit = 0, n_miss = 0, n_busy = 0, n_release = 0, n_unheld = 0, n_wb = 0;

  sector_cache_lru_directory_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_kind          (in_kind),
    .in_device_id     (in_device_id),
    .in_sector        (in_sector),
    .in_coherent      (in_coherent),
    .in_dirty_release (in_dirty_release),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_slot         (out_slot),
    .out_dirty_evict  (out_dirty_evict),
    .out_old_device   (out_old_device),
    .out_old_sector   (out_old_sector),
    .out_fetch_needed (out_fetch_needed)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #15_000_000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic access_t make_access(logic kind, logic [2:0] dev, logic [31:0] sec,
                                          logic coh, logic dirty);
    access_t a;
    a.kind  = kind;
    a.dev   = dev;
    a.sec   = sec;
    a.coh   = coh;
    a.dirty = dirty;
    return a;
  endfunction

  function automatic access_t fresh_map();
    return make_access(KIND_MAP, 3'($urandom_range(0, 7)), $urandom,
                       1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
  endfunction

  function automatic int count_held();
    int n;
    n = 0;
    for (int i = 0; i < SLOTS; i++)
      if (dir_held[i]) n++;
    return n;
  endfunction

  // Works out the grant for one request and updates the shadow directory.
  task automatic predict_access(input access_t a, output grant_t g);
    int                 hit;
    int                 vic;
    logic [STAMP_W-1:0] best;
    hit  = -1;
    vic  = -1;
    best = '0;
    g    = '0;
    if (a.kind == KIND_UNMAP) begin
      for (int i = 0; i < SLOTS; i++)
        if (hit < 0 && dir_valid[i] && dir_held[i] && dir_dev[i] == a.dev &&
            dir_sec[i] == a.sec) hit = i;
      if (hit < 0) begin
        g.status = ST_UNHELD;
        n_unheld++;
      end else begin
        dir_held[hit]  = 1'b0;
        dir_stamp[hit] = use_ctr;
        use_ctr        = use_ctr + STAMP_W'(1);
        if (a.dirty) dir_dirty[hit] = 1'b1;
        g.status = ST_HIT;
        g.slot   = hit[SLOT_W-1:0];
        n_release++;
      end
    end else begin
      for (int i = 0; i < SLOTS; i++)
        if (hit < 0 && dir_valid[i] && dir_dev[i] == a.dev && dir_sec[i] == a.sec) hit = i;
      if (hit >= 0) begin
        g.slot = hit[SLOT_W-1:0];
        if (dir_held[hit]) begin
          g.status = ST_BUSY;
          n_busy++;
        end else begin
          dir_held[hit] = 1'b1;
          g.status = ST_HIT;
          n_hit++;
        end
      end else begin
        for (int i = 0; i < SLOTS; i++)
          if (!dir_held[i] && (vic < 0 || dir_stamp[i] < best)) begin
            vic  = i;
            best = dir_stamp[i];
          end
        if (vic < 0) begin
          g.status = ST_BUSY;
          n_busy++;
        end else begin
          g.status = ST_MISS;
          g.slot   = vic[SLOT_W-1:0];
          g.fetch  = a.coh;
          if (dir_valid[vic] && dir_dirty[vic]) begin
            g.wb   = 1'b1;
            g.odev = dir_dev[vic];
            g.osec = dir_sec[vic];
            n_wb++;
          end
          dir_valid[vic] = 1'b1;
          dir_dev[vic]   = a.dev;
          dir_sec[vic]   = a.sec;
          dir_dirty[vic] = 1'b0;
          dir_held[vic]  = 1'b1;
          n_miss++;
        end
      end
    end
  endtask

  // Mostly well-formed traffic: maps, mostly of a small set of hot tags, releases of
  // held slots, and some unmaps of tags that may not be held.
  function automatic access_t random_access();
    access_t a;
    int      n;
    int      roll;
    int      k;
    int      pick;
    int      j;
    a       = fresh_map();
    n       = count_held();
    roll    = $urandom_range(0, 99);
    pick    = 0;
    if ($urandom_range(0, 9) < 6) begin
      j     = $urandom_range(0, POOL - 1);
      a.dev = pool_dev[j];
      a.sec = pool_sec[j];
    end
    if (n > 0 && roll < 40) begin
      k = $urandom_range(0, n - 1);
      for (int i = 0; i < SLOTS; i++)
        if (dir_held[i]) begin
          if (k == 0) pick = i;
          k--;
        end
      a.kind = KIND_UNMAP;
      a.dev  = dir_dev[pick];
      a.sec  = dir_sec[pick];
    end else if (roll < 48) begin
      a.kind = KIND_UNMAP;
    end
    return a;
  endfunction

  task automatic send_item(input access_t a);
    grant_t g;
    int     gap;
    if (tx_idle && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 14);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_kind          <= a.kind;
    in_device_id     <= a.dev;
    in_sector        <= a.sec;
    in_coherent      <= a.coh;
    in_dirty_release <= a.dirty;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_access(a, g);
    grant_q.push_back(g);
    n_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (grant_q.size() != 0) @(posedge clk);
  endtask

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      n_fail++;
    end
  endfunction

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_req = 1'b0;
      end else if (rx_idle && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 14) - 1) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (grant_q.size() == 0) begin
        $error("unexpected result: status %0d slot %0d", out_status, out_slot);
        n_fail++;
      end else begin
        head = grant_q.pop_front();
        check_field("status", head.status, out_status);
        check_field("slot", head.slot, out_slot);
        check_field("dirty_evict", head.wb, out_dirty_evict);
        check_field("old_device", head.odev, out_old_device);
        check_field("old_sector", head.osec, out_old_sector);
        check_field("fetch_needed", head.fetch, out_fetch_needed);
      end
    end
  end

  // Field extremes, hit and miss, held hit, unheld unmap, dirty release.
  task automatic test_directed();
    send_item(make_access(KIND_MAP, 3'd0, 32'h0000_0000, 1'b0, 1'b0));
    send_item(make_access(KIND_MAP, 3'd7, 32'hFFFF_FFFF, 1'b1, 1'b1));
    send_item(make_access(KIND_MAP, 3'd7, 32'hFFFF_FFFF, 1'b1, 1'b0));
    send_item(make_access(KIND_UNMAP, 3'd7, 32'hFFFF_FFFF, 1'b0, 1'b1));
    send_item(make_access(KIND_UNMAP, 3'd7, 32'hFFFF_FFFF, 1'b1, 1'b1));
    send_item(make_access(KIND_UNMAP, 3'd5, 32'h1234_5678, 1'b0, 1'b0));
    send_item(make_access(KIND_MAP, 3'd7, 32'hFFFF_FFFF, 1'b1, 1'b0));
    send_item(make_access(KIND_UNMAP, 3'd7, 32'hFFFF_FFFF, 1'b0, 1'b0));
    send_item(make_access(KIND_UNMAP, 3'd0, 32'h0000_0000, 1'b1, 1'b0));
    send_item(make_access(KIND_MAP, 3'd3, 32'h0000_0000, 1'b1, 1'b0));
    send_item(make_access(KIND_MAP, 3'd0, 32'h0000_0001, 1'b0, 1'b1));
    send_item(make_access(KIND_MAP, 3'd0, 32'h8000_0000, 1'b1, 1'b1));
    send_item(make_access(KIND_UNMAP, 3'd3, 32'h0000_0000, 1'b0, 1'b1));
    send_item(make_access(KIND_UNMAP, 3'd4, 32'h0000_0001, 1'b0, 1'b0));
    send_item(make_access(KIND_UNMAP, 3'd0, 32'h0000_0001, 1'b1, 1'b1));
    send_item(make_access(KIND_MAP, 3'd3, 32'h0000_0000, 1'b0, 1'b0));
    send_item(make_access(KIND_UNMAP, 3'd0, 32'h8000_0000, 1'b0, 1'b0));
    send_item(make_access(KIND_UNMAP, 3'd3, 32'h0000_0000, 1'b0, 1'b0));
  endtask

  // Hold every slot, ask for more, then release all and evict in LRU order.
  task automatic test_fill_and_evict();
    int held_idx[$];
    int j;
    int t;
    while (count_held() < SLOTS) send_item(fresh_map());
    repeat (3) send_item(fresh_map());
    send_item(make_access(KIND_MAP, dir_dev[5], dir_sec[5], 1'b1, 1'b0));
    for (int i = 0; i < SLOTS; i++) held_idx.push_back(i);
    for (int i = SLOTS - 1; i > 0; i--) begin
      j           = $urandom_range(0, i);
      t           = held_idx[i];
      held_idx[i] = held_idx[j];
      held_idx[j] = t;
    end
    foreach (held_idx[i])
      send_item(make_access(KIND_UNMAP, dir_dev[held_idx[i]], dir_sec[held_idx[i]],
                            1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
    repeat (12) send_item(fresh_map());
  endtask

  task automatic test_random_mix(input int n);
    repeat (n) send_item(random_access());
  endtask

  // The receiver holds off while items keep coming, then the sender waits
  // for every outstanding result before going on.
  task automatic test_backpressure();
    hold_req = 1'b1;
    repeat (6) send_item(random_access());
    wait_drained();
    repeat (4) send_item(random_access());
  endtask

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      dir_valid[i] = 1'b0;
      dir_dev[i]   = '0;
      dir_sec[i]   = '0;
      dir_stamp[i] = '0;
      dir_dirty[i] = 1'b0;
      dir_held[i]  = 1'b0;
    end
    use_ctr = 1;
    pool_dev[0] = 3'd0;
    pool_sec[0] = 32'h0000_0000;
    pool_dev[1] = 3'd7;
    pool_sec[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < POOL; i++) begin
      pool_dev[i] = 3'($urandom_range(0, 7));
      pool_sec[i] = $urandom;
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_fill_and_evict();
    test_random_mix(750);
    test_backpressure();
    test_fill_and_evict();
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    test_random_mix(250);

    wait_drained();
    repeat (SETTLE) @(posedge clk);
    $display("Sent %0d items: %0d hits, %0d misses, %0d busy answers, %0d releases,",
             n_sent, n_hit, n_miss, n_busy, n_release);
    $display("%0d unmaps of unheld sectors and %0d dirty evictions.", n_unheld, n_wb);
    if (n_fail == 0 && grant_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
